/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros for the design folder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is high
`define CHK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check, also active during reset
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/wmul256_pkg.sv */
// ----------------------------------------------------------------------------
// wmul256_pkg
// widths and types of the 256-bit column-wise integer multiplier
// ----------------------------------------------------------------------------
package wmul256_pkg;

   localparam int WORD_BITS    = 64;
   localparam int WORD_COUNT   = 4;
   localparam int HALF_BITS    = WORD_BITS / 2;
   localparam int HALF_COUNT   = 2 * WORD_COUNT;
   localparam int OPERAND_BITS = WORD_COUNT * WORD_BITS;
   localparam int PROD_WORDS   = 2 * WORD_COUNT;
   localparam int PROD_BITS    = PROD_WORDS * WORD_BITS;
   localparam int PP_BITS      = 2 * HALF_BITS;
   localparam int COL_COUNT    = 2 * HALF_COUNT - 1;
   localparam int COL_BITS     = PP_BITS + $clog2(HALF_COUNT);
   localparam int TOP_BITS     = COL_BITS - PP_BITS;

   typedef logic [WORD_BITS-1:0]    word_type;
   typedef logic [HALF_BITS-1:0]    half_type;
   typedef logic [OPERAND_BITS-1:0] operand_type;
   typedef logic [PP_BITS-1:0]      pp_type;
   typedef logic [COL_BITS-1:0]     col_type;
   typedef logic [PROD_BITS-1:0]    product_type;
   typedef logic [WORD_BITS:0]      chunk_type;

endpackage

/* design/wide_integer_multiplier_256_top.sv */
// ----------------------------------------------------------------------------
// wide_integer_multiplier_256_top
// 256 x 256 -> 512-bit unsigned multiplier, multiply or square a
// throughput: one item per cycle, busy is always low
// stages: operand capture, 32x32 partial products, column sums,
//         3:2 compression, per-word carry-select add, carry resolve
// reset clears only the stage valid bits, no results appear after reset
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wide_integer_multiplier_256_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_mode,
   input  wmul256_pkg::word_type req_a_word_0,
   input  wmul256_pkg::word_type req_a_word_1,
   input  wmul256_pkg::word_type req_a_word_2,
   input  wmul256_pkg::word_type req_a_word_3,
   input  wmul256_pkg::word_type req_b_word_0,
   input  wmul256_pkg::word_type req_b_word_1,
   input  wmul256_pkg::word_type req_b_word_2,
   input  wmul256_pkg::word_type req_b_word_3,
   output logic                  rsp_valid,
   output wmul256_pkg::word_type rsp_product_word_0,
   output wmul256_pkg::word_type rsp_product_word_1,
   output wmul256_pkg::word_type rsp_product_word_2,
   output wmul256_pkg::word_type rsp_product_word_3,
   output wmul256_pkg::word_type rsp_product_word_4,
   output wmul256_pkg::word_type rsp_product_word_5,
   output wmul256_pkg::word_type rsp_product_word_6,
   output wmul256_pkg::word_type rsp_product_word_7
);
   import wmul256_pkg::*;

   // valid bits
   logic        op_valid_ff, pp_valid_ff, col_valid_ff, csa_valid_ff, chunk_valid_ff;
   logic        rsp_valid_ff;
   logic        op_valid_in;

   // payload
   operand_type a_ff, b_ff, a_in, b_in;
   pp_type      pp_ff  [HALF_COUNT][HALF_COUNT];
   pp_type      pp_in  [HALF_COUNT][HALF_COUNT];
   col_type     col_ff [COL_COUNT];
   col_type     col_in [COL_COUNT];
   product_type sum_ff, carry_ff, sum_in, carry_in;
   chunk_type   g0_ff [PROD_WORDS];
   chunk_type   g1_ff [PROD_WORDS];
   chunk_type   g0_in [PROD_WORDS];
   chunk_type   g1_in [PROD_WORDS];
   product_type res_ff, res_in;

   product_type x_vec, y_vec, z_vec, maj_vec;
   logic        carry_chain;

   assign busy        = 1'b0;
   assign op_valid_in = start && !busy;

   assign a_in = {req_a_word_3, req_a_word_2, req_a_word_1, req_a_word_0};
   assign b_in = req_mode ? a_in
                          : {req_b_word_3, req_b_word_2, req_b_word_1, req_b_word_0};

   // partial products of half words
   always_comb begin
      for (int u = 0; u < HALF_COUNT; u++) begin
         for (int v = 0; v < HALF_COUNT; v++) begin
            pp_in[u][v] = PP_BITS'(a_ff[u*HALF_BITS +: HALF_BITS])
                        * PP_BITS'(b_ff[v*HALF_BITS +: HALF_BITS]);
         end
      end
   end

   // half-word column sums
   always_comb begin
      for (int k = 0; k < COL_COUNT; k++) begin
         col_in[k] = '0;
         for (int u = 0; u < HALF_COUNT; u++) begin
            for (int v = 0; v < HALF_COUNT; v++) begin
               if (u + v == k) begin
                  col_in[k] = col_in[k] + COL_BITS'(pp_ff[u][v]);
               end
            end
         end
      end
   end

   // split columns into three non-overlapping vectors and compress
   always_comb begin
      x_vec = '0;
      y_vec = '0;
      z_vec = '0;
      for (int k = 0; k < COL_COUNT; k++) begin
         x_vec[k*HALF_BITS +: HALF_BITS]     = col_ff[k][HALF_BITS-1:0];
         y_vec[(k+1)*HALF_BITS +: HALF_BITS] = col_ff[k][PP_BITS-1:HALF_BITS];
         if (k + 2 < 2 * HALF_COUNT) begin
            z_vec[(k+2)*HALF_BITS +: TOP_BITS] = col_ff[k][COL_BITS-1:PP_BITS];
         end
      end
      sum_in   = x_vec ^ y_vec ^ z_vec;
      maj_vec  = (x_vec & y_vec) | (x_vec & z_vec) | (y_vec & z_vec);
      carry_in = {maj_vec[PROD_BITS-2:0], 1'b0};
   end

   // per-word sums with and without carry in
   always_comb begin
      for (int w = 0; w < PROD_WORDS; w++) begin
         g0_in[w] = {1'b0, sum_ff[w*WORD_BITS +: WORD_BITS]}
                  + {1'b0, carry_ff[w*WORD_BITS +: WORD_BITS]};
         g1_in[w] = g0_in[w] + (WORD_BITS+1)'(1);
      end
   end

   // carry resolve across words
   always_comb begin
      carry_chain = 1'b0;
      res_in      = '0;
      for (int w = 0; w < PROD_WORDS; w++) begin
         if (carry_chain) begin
            res_in[w*WORD_BITS +: WORD_BITS] = g1_ff[w][WORD_BITS-1:0];
            carry_chain                      = g1_ff[w][WORD_BITS];
         end else begin
            res_in[w*WORD_BITS +: WORD_BITS] = g0_ff[w][WORD_BITS-1:0];
            carry_chain                      = g0_ff[w][WORD_BITS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff    <= 1'b0;
         pp_valid_ff    <= 1'b0;
         col_valid_ff   <= 1'b0;
         csa_valid_ff   <= 1'b0;
         chunk_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         op_valid_ff    <= op_valid_in;
         pp_valid_ff    <= op_valid_ff;
         col_valid_ff   <= pp_valid_ff;
         csa_valid_ff   <= col_valid_ff;
         chunk_valid_ff <= csa_valid_ff;
         rsp_valid_ff   <= chunk_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      pp_ff    <= pp_in;
      col_ff   <= col_in;
      sum_ff   <= sum_in;
      carry_ff <= carry_in;
      g0_ff    <= g0_in;
      g1_ff    <= g1_in;
      res_ff   <= res_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_product_word_0 = res_ff[0*WORD_BITS +: WORD_BITS];
   assign rsp_product_word_1 = res_ff[1*WORD_BITS +: WORD_BITS];
   assign rsp_product_word_2 = res_ff[2*WORD_BITS +: WORD_BITS];
   assign rsp_product_word_3 = res_ff[3*WORD_BITS +: WORD_BITS];
   assign rsp_product_word_4 = res_ff[4*WORD_BITS +: WORD_BITS];
   assign rsp_product_word_5 = res_ff[5*WORD_BITS +: WORD_BITS];
   assign rsp_product_word_6 = res_ff[6*WORD_BITS +: WORD_BITS];
   assign rsp_product_word_7 = res_ff[7*WORD_BITS +: WORD_BITS];

   `CHK_ASSERT(a_item_gives_result, clock, reset, (start && !busy) |-> ##6 rsp_valid, "item lost in pipeline")
   `CHK_ASSERT(a_result_has_item, clock, reset, rsp_valid |-> $past(start && !busy, 6), "result without item")
   `CHK_ASSERT(a_low_bit, clock, reset, rsp_valid |-> (rsp_product_word_0[0] == $past(req_a_word_0[0] && (req_mode ? req_a_word_0[0] : req_b_word_0[0]), 6)), "product low bit wrong")
   `CHK_ASSERT_ALWAYS(a_reset_quiet, clock, ($past(reset) && !reset) |-> !rsp_valid, "result right after reset")

endmodule
